### hw/rtl/rve_pkg.sv
package rve_pkg;

    localparam int CHANNELS_DEF   = 8;
    localparam int HIST_DEPTH_DEF = 8;

    localparam int CH_W    = 3;
    localparam int RANGE_W = 13;
    localparam int TIME_W  = 32;
    localparam int VEL_W   = 24;
    localparam int NUM_W   = 33;
    localparam int CFG_IDX_W = 2;

    localparam int LOOKBACK  = 4;
    localparam int US_PER_S  = 1000000;
    localparam int VEL_LIMIT = 8191000;

    localparam logic signed [VEL_W-1:0] SENTINEL = -24'sd100000;
    localparam logic signed [VEL_W-1:0] VEL_MAX  = 24'sd8191000;
    localparam logic signed [VEL_W-1:0] VEL_MIN  = -24'sd8191000;

    localparam logic [TIME_W-1:0] MIN_INTERVAL_RST = 32'd1000;
    localparam logic [TIME_W-1:0] MAX_INTERVAL_RST = 32'd5000000;
    localparam logic [TIME_W-1:0] STALE_RST        = 32'd100000;

    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_POLL   = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_INTERVAL = 2'd0,
        CFG_MAX_INTERVAL = 2'd1,
        CFG_STALE        = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic               command;
        logic [CH_W-1:0]    channel;
        logic [RANGE_W-1:0] range_mm;
        logic [TIME_W-1:0]  now_us;
    } t_in_item;

    typedef struct packed {
        logic [CH_W-1:0]          out_channel;
        logic signed [VEL_W-1:0]  velocity_mm_s;
    } t_res_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [TIME_W-1:0]    wdata;
    } t_cfg_wr;

endpackage

### hw/rtl/rve_chan_if.sv
interface rve_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/rve_ram.sv
module rve_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### hw/rtl/rve_divider.sv
module rve_divider #(
    parameter int NUM_W = rve_pkg::NUM_W,
    parameter int DEN_W = rve_pkg::TIME_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_num;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0]   shifted;
    logic             fits;
    logic [DEN_W:0]   diff;

    // one quotient bit per cycle, restoring
    always_comb begin
        shifted = {r_rem, r_num[NUM_W-1]};
        fits    = (shifted >= {1'b0, r_den});
        diff    = shifted - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_rem <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_start) else $error("divider restarted while busy");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("divider done without a run");
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_den != '0) |-> (r_rem < r_den))
        else $error("divider remainder out of range");
endmodule

### hw/rtl/range_velocity_estimator_unit.sv
// Range velocity estimator: per-channel closing speed from range samples.
// i_in takes one item per transfer: a range sample or a poll for one channel,
// with the current microsecond time. o_res gives exactly one result per item,
// in order: the channel and its velocity in mm/s (-100000 = invalid or stale).
// i_cfg writes min interval (0), max interval (1) and stale timeout (2);
// other indexes are dropped. It is always ready; write it only while idle.
// The history and per-channel state live in two single-port-read RAMs.
// A sample inside the interval window goes from transfer to result through
// channel read, history read, divider start and a 33-bit one-bit-per-cycle divide.
// A poll or an interval miss skips the divide; an out-of-range channel also
// skips the history read. One item is worked on at a time: the next is taken
// once the result sits in the output register, and not before. A stalled
// receiver holds one result and the block then waits before writing the next
// one back.
// After reset both RAMs are swept to zero, one entry a cycle, over all
// 1 << HAW history addresses (64 by default); i_in is not ready during the
// sweep.
module range_velocity_estimator_unit #(
    parameter int CHANNELS   = rve_pkg::CHANNELS_DEF,
    parameter int HIST_DEPTH = rve_pkg::HIST_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rve_chan_if.sink    i_in,
    rve_chan_if.source  o_res,
    rve_chan_if.sink    i_cfg
);
    import rve_pkg::*;

    localparam int PW     = $clog2(HIST_DEPTH);
    localparam int CIW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int HAW    = CIW + PW;
    localparam int HIST_W = RANGE_W + TIME_W;
    localparam int CHAN_W = PW + TIME_W + VEL_W;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_CHAN  = 6'b000100,
        S_HIST  = 6'b001000,
        S_DIV   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state;

    logic [HAW-1:0]          r_clr_cnt;
    t_in_item                r_item;
    logic                    r_ch_ok;
    logic [CIW-1:0]          r_idx;
    logic [PW-1:0]           r_slot;
    logic [TIME_W-1:0]       r_start;
    logic [TIME_W-1:0]       r_tnew;
    logic signed [VEL_W-1:0] r_vel;
    logic                    r_neg;

    logic [TIME_W-1:0] r_min_int;
    logic [TIME_W-1:0] r_max_int;
    logic [TIME_W-1:0] r_stale;

    logic      r_out_valid;
    t_res_item r_out;

    // memory ports
    logic              hist_we;
    logic [HAW-1:0]    hist_waddr;
    logic [HIST_W-1:0] hist_wdata;
    logic [HAW-1:0]    hist_raddr;
    logic [HIST_W-1:0] hist_rdata;
    logic              chan_we;
    logic [CIW-1:0]    chan_waddr;
    logic [CHAN_W-1:0] chan_wdata;
    logic [CIW-1:0]    chan_raddr;
    logic [CHAN_W-1:0] chan_rdata;

    logic [PW-1:0]           rd_ptr;
    logic [TIME_W-1:0]       rd_start;
    logic signed [VEL_W-1:0] rd_vel;
    logic [RANGE_W-1:0]      rd_range;
    logic [TIME_W-1:0]       rd_time;

    logic [PW-1:0]    slot_p;
    logic [PW:0]      slot_sum;
    logic [PW-1:0]    slot_q;
    logic [TIME_W-1:0] dt;
    logic [TIME_W-1:0] age;
    logic              dt_ok;
    logic [RANGE_W-1:0] abs_dd;
    logic [NUM_W-1:0]   product;
    logic               out_free;
    logic               is_sample;

    logic               div_start;
    logic               div_done;
    logic [NUM_W-1:0]   div_quo;
    logic [VEL_W-1:0]   mag;

    assign {rd_ptr, rd_start, rd_vel} = chan_rdata;
    assign {rd_range, rd_time}        = hist_rdata;
    assign is_sample = (r_item.command == CMD_SAMPLE);
    assign out_free  = !r_out_valid || o_res.ready;

    // ring slot arithmetic: next slot and the slot four ahead of it
    always_comb begin
        slot_p   = (rd_ptr == PW'(HIST_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
        slot_sum = {1'b0, slot_p} + (PW+1)'(LOOKBACK);
        slot_q   = (slot_sum >= (PW+1)'(HIST_DEPTH))
                   ? PW'(slot_sum - (PW+1)'(HIST_DEPTH)) : slot_sum[PW-1:0];
    end

    always_comb begin
        dt     = r_tnew - rd_time;
        age    = r_item.now_us - rd_time;
        dt_ok  = (dt > r_min_int) && (dt < r_max_int);
        abs_dd = (r_item.range_mm > rd_range) ? r_item.range_mm - rd_range
                                              : rd_range - r_item.range_mm;
        product = NUM_W'(abs_dd) * NUM_W'(US_PER_S);
        mag     = (div_quo > NUM_W'(VEL_LIMIT)) ? VEL_W'(VEL_LIMIT) : div_quo[VEL_W-1:0];
    end

    always_comb begin
        hist_we    = 1'b0;
        hist_waddr = {r_idx, slot_p};
        hist_wdata = {r_item.range_mm, rd_start};
        hist_raddr = {r_idx, is_sample ? slot_q : rd_ptr};
        chan_we    = 1'b0;
        chan_waddr = r_idx;
        chan_wdata = {r_slot, r_start, r_vel};
        chan_raddr = CIW'(i_in.data.channel);
        case (r_state)
            S_CLEAR: begin
                hist_we    = 1'b1;
                hist_waddr = r_clr_cnt;
                hist_wdata = '0;
                chan_we    = 1'b1;
                chan_waddr = r_clr_cnt[CIW-1:0];
                chan_wdata = '0;
            end
            S_CHAN: begin
                hist_we = r_ch_ok && is_sample;
            end
            S_DONE: begin
                chan_we = r_ch_ok && out_free;
            end
            default: begin
            end
        endcase
    end

    assign div_start = (r_state == S_HIST) && is_sample && dt_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_cnt <= '0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr_cnt <= r_clr_cnt + 1'b1;
                    if (r_clr_cnt == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_state <= S_CHAN;
                    end
                end
                S_CHAN: begin
                    r_state <= r_ch_ok ? S_HIST : S_DONE;
                end
                S_HIST: begin
                    r_state <= div_start ? S_DIV : S_DONE;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // per-item payload registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_item  <= i_in.data;
                r_idx   <= CIW'(i_in.data.channel);
                r_ch_ok <= (32'(i_in.data.channel) < 32'(CHANNELS));
            end
            S_CHAN: begin
                r_vel  <= r_ch_ok ? rd_vel : SENTINEL;
                r_tnew <= rd_start;
                if (is_sample) begin
                    r_slot  <= slot_p;
                    r_start <= r_item.now_us;
                end else begin
                    r_slot  <= rd_ptr;
                    r_start <= rd_start;
                end
            end
            S_HIST: begin
                r_neg <= (r_item.range_mm > rd_range);
                if (is_sample) begin
                    if (!dt_ok) begin
                        r_vel <= SENTINEL;
                    end
                end else if (age > r_stale) begin
                    r_vel <= SENTINEL;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    r_vel <= r_neg ? -$signed(mag) : $signed(mag);
                end
            end
            default: begin
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out.out_channel   <= r_item.channel;
            r_out.velocity_mm_s <= r_vel;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_int <= MIN_INTERVAL_RST;
            r_max_int <= MAX_INTERVAL_RST;
            r_stale   <= STALE_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.index)
                CFG_MIN_INTERVAL: r_min_int <= i_cfg.data.wdata;
                CFG_MAX_INTERVAL: r_max_int <= i_cfg.data.wdata;
                CFG_STALE:        r_stale   <= i_cfg.data.wdata;
                default: begin
                end
            endcase
        end
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    rve_ram #(
        .WIDTH (HIST_W),
        .DEPTH (1 << HAW)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (hist_waddr),
        .i_wdata (hist_wdata),
        .i_raddr (hist_raddr),
        .o_rdata (hist_rdata)
    );

    rve_ram #(
        .WIDTH (CHAN_W),
        .DEPTH (1 << CIW)
    ) u_chan_ram (
        .i_clk   (i_clk),
        .i_we    (chan_we),
        .i_waddr (chan_waddr),
        .i_wdata (chan_wdata),
        .i_raddr (chan_raddr),
        .o_rdata (chan_rdata)
    );

    rve_divider #(
        .NUM_W (NUM_W),
        .DEN_W (TIME_W)
    ) u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (product),
        .i_den   (dt),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !i_in.ready) else $error("input taken during clear");
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV)) else $error("divider result outside divide");
    a_bad_channel_sentinel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free && !r_ch_ok)
        |=> (o_res.data.velocity_mm_s == SENTINEL))
        else $error("out-of-range channel without sentinel");
    a_velocity_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.data.velocity_mm_s == SENTINEL)
        || (o_res.data.velocity_mm_s >= VEL_MIN && o_res.data.velocity_mm_s <= VEL_MAX))
        else $error("velocity out of range");
    a_no_mem_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!hist_we && !chan_we))
        else $error("memory written while idle");
endmodule

### tb/range_velocity_estimator_unit_tb.sv
module range_velocity_estimator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rve_pkg::*;

    localparam int N_CH         = CHANNELS_DEF;
    localparam int N_HIST       = HIST_DEPTH_DEF;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int LONG_STALL   = 400;
    localparam int SETTLE       = 8;
    localparam int TAIL_CYCLES  = 60;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    rve_chan_if #(.T(t_in_item))  in_if  ();
    rve_chan_if #(.T(t_res_item)) res_if ();
    rve_chan_if #(.T(t_cfg_wr))   cfg_if ();

    range_velocity_estimator_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state, mirrors the per-channel history of the block
    logic [RANGE_W-1:0]      rng_hist [N_CH][N_HIST];
    logic [TIME_W-1:0]       tim_hist [N_CH][N_HIST];
    int unsigned             ring_ptr [N_CH];
    logic [TIME_W-1:0]       start_us [N_CH];
    logic signed [VEL_W-1:0] vel_reg  [N_CH];
    logic [TIME_W-1:0]       min_iv;
    logic [TIME_W-1:0]       max_iv;
    logic [TIME_W-1:0]       stale_us;

    t_res_item vel_expected[$];

    // stimulus time base per channel
    logic [TIME_W-1:0] chan_us [N_CH];

    bit          idle_on    = 1'b1;
    int unsigned n_items    = 0;
    int unsigned n_samples  = 0;
    int unsigned n_polls    = 0;
    int unsigned n_valid    = 0;
    int unsigned n_stale    = 0;
    int unsigned n_results  = 0;
    int unsigned n_errors   = 0;
    int unsigned cycle_cnt  = 0;
    int unsigned stall_req  = 0;
    int unsigned stall_done = 0;

    logic        res_hold  = 1'b0;
    logic        rdy_burst = 1'b0;
    int unsigned rdy_left  = 0;

    function automatic t_res_item estimate_velocity(t_in_item it);
        t_res_item         res;
        int unsigned       ch;
        int unsigned       p;
        int unsigned       q;
        logic [TIME_W-1:0] dt;
        logic [TIME_W-1:0] age;
        longint            d_mm;
        longint            span;
        longint            v;
        ch = it.channel;
        res.out_channel   = it.channel;
        res.velocity_mm_s = SENTINEL;
        if (ch < N_CH) begin
            if (it.command == CMD_SAMPLE) begin
                n_samples++;
                p = (ring_ptr[ch] + 1) % N_HIST;
                q = (p + LOOKBACK) % N_HIST;
                ring_ptr[ch]    = p;
                rng_hist[ch][p] = it.range_mm;
                tim_hist[ch][p] = start_us[ch];
                start_us[ch]    = it.now_us;
                dt = tim_hist[ch][p] - tim_hist[ch][q];
                if (dt > min_iv && dt < max_iv) begin
                    d_mm = longint'(rng_hist[ch][p]) - longint'(rng_hist[ch][q]);
                    span = longint'(dt);
                    v = (-d_mm * US_PER_S) / span;
                    if (v > VEL_LIMIT) v = VEL_LIMIT;
                    if (v < -VEL_LIMIT) v = -VEL_LIMIT;
                    vel_reg[ch] = v[VEL_W-1:0];
                    n_valid++;
                end else begin
                    vel_reg[ch] = SENTINEL;
                end
            end else begin
                n_polls++;
                age = it.now_us - tim_hist[ch][ring_ptr[ch]];
                if (age > stale_us) begin
                    vel_reg[ch] = SENTINEL;
                    n_stale++;
                end
            end
            res.velocity_mm_s = vel_reg[ch];
        end
        return res;
    endfunction

    task automatic reset_predictor();
        for (int c = 0; c < N_CH; c++) begin
            for (int h = 0; h < N_HIST; h++) begin
                rng_hist[c][h] = '0;
                tim_hist[c][h] = '0;
            end
            ring_ptr[c] = 0;
            start_us[c] = '0;
            vel_reg[c]  = '0;
        end
        min_iv   = MIN_INTERVAL_RST;
        max_iv   = MAX_INTERVAL_RST;
        stale_us = STALE_RST;
    endtask

    // valid is left high after a transfer so back-to-back items never toggle it
    task automatic push_range_item(input t_in_item it);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        vel_expected.push_back(estimate_velocity(it));
        n_items++;
    endtask

    task automatic send_cmd(input logic cmd, input int ch, input int range_mm,
                            input logic [TIME_W-1:0] now);
        t_in_item it;
        it.command  = cmd;
        it.channel  = ch[CH_W-1:0];
        it.range_mm = range_mm[RANGE_W-1:0];
        it.now_us   = now;
        push_range_item(it);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= {idx, val};
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        case (idx)
            CFG_MIN_INTERVAL: min_iv   = val;
            CFG_MAX_INTERVAL: max_iv   = val;
            CFG_STALE:        stale_us = val;
            default: ;
        endcase
    endtask

    task automatic set_limits(input logic [TIME_W-1:0] lo, input logic [TIME_W-1:0] hi,
                              input logic [TIME_W-1:0] stale);
        write_reg(CFG_MIN_INTERVAL, lo);
        write_reg(CFG_MAX_INTERVAL, hi);
        write_reg(CFG_STALE, stale);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic drain_block(input int settle);
        in_if.valid <= 1'b0;
        while (vel_expected.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic run_random(input int count);
        t_in_item it;
        int       sel;
        int       c;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            c   = $urandom_range(0, N_CH - 1);
            it.channel  = c[CH_W-1:0];
            it.range_mm = RANGE_W'($urandom_range(0, 8191));
            if ($urandom_range(0, 7) == 0)
                it.range_mm = $urandom_range(0, 1) ? '1 : '0;
            if (sel < 75) begin
                // well-formed sample stream, mostly inside the interval window
                it.command = CMD_SAMPLE;
                if ($urandom_range(0, 9) == 0)
                    chan_us[c] = chan_us[c] + $urandom_range(0, 400);
                else
                    chan_us[c] = chan_us[c] + $urandom_range(250, 1200000);
                it.now_us = chan_us[c];
            end else if (sel < 93) begin
                it.command = CMD_POLL;
                it.now_us  = chan_us[c] + $urandom_range(0, 300000);
            end else begin
                it.command = 1'($urandom_range(0, 1));
                it.now_us  = $urandom;
            end
            push_range_item(it);
        end
    endtask

    task automatic test_reset_defaults();
        logic [TIME_W-1:0] t;
        // a fresh channel is not stale at exactly the timeout, stale just past it
        send_cmd(CMD_POLL, 0, 0, STALE_RST);
        send_cmd(CMD_POLL, 1, 8191, STALE_RST + 1);
        // samples on channel 2 whose time base wraps through zero
        for (int k = 1; k <= 6; k++) begin
            t = 32'hFFFF_0000 + 32'(20000 * k);
            case (k)
                1, 6:    send_cmd(CMD_SAMPLE, 2, 8191, t);
                5:       send_cmd(CMD_SAMPLE, 2, 0, t);
                default: send_cmd(CMD_SAMPLE, 2, 100 * k, t);
            endcase
        end
        // interval equal to the lower limit, then one just above it
        send_cmd(CMD_SAMPLE, 5, 8191, 32'd250);
        send_cmd(CMD_SAMPLE, 5, 0, 32'd500);
        send_cmd(CMD_SAMPLE, 5, 8191, 32'd750);
        send_cmd(CMD_SAMPLE, 5, 8191, 32'd1000);
        send_cmd(CMD_SAMPLE, 5, 8191, 32'd1251);
        send_cmd(CMD_SAMPLE, 5, 8191, 32'hFFFF_FFFF);
    endtask

    task automatic test_unknown_register();
        logic [TIME_W-1:0] newest;
        drain_block(SETTLE);
        write_reg(CFG_UNUSED, 32'd0);
        cfg_if.valid <= 1'b0;
        newest = tim_hist[2][ring_ptr[2]];
        send_cmd(CMD_POLL, 2, 0, newest + STALE_RST);
        send_cmd(CMD_POLL, 2, 0, newest + STALE_RST + 1);
    endtask

    task automatic test_random_default();
        for (int c = 0; c < N_CH; c++) chan_us[c] = $urandom;
        run_random(400);
    endtask

    task automatic test_saturation();
        drain_block(SETTLE);
        set_limits('0, '1, '0);
        // tiny intervals with full-scale range steps clip both ways
        send_cmd(CMD_SAMPLE, 4, 8191, 32'd1);
        send_cmd(CMD_SAMPLE, 4, 0, 32'd2);
        send_cmd(CMD_SAMPLE, 4, 4000, 32'd3);
        send_cmd(CMD_SAMPLE, 4, 4000, 32'd4);
        send_cmd(CMD_SAMPLE, 4, 0, 32'd5);
        send_cmd(CMD_SAMPLE, 4, 8191, 32'd6);
        send_cmd(CMD_POLL, 4, 0, 32'd5);
        send_cmd(CMD_POLL, 4, 0, 32'd6);
    endtask

    task automatic test_random_wide();
        run_random(200);
    endtask

    task automatic test_random_closed();
        drain_block(SETTLE);
        set_limits('1, '0, '1);
        run_random(150);
    endtask

    task automatic test_random_stall();
        drain_block(SETTLE);
        set_limits($urandom_range(0, 3000), $urandom_range(200000, 3000000),
                   $urandom_range(1000, 200000));
        stall_req++;
        run_random(400);
    endtask

    task automatic test_random_streaming();
        drain_block(SETTLE);
        set_limits(MIN_INTERVAL_RST, MAX_INTERVAL_RST, STALE_RST);
        idle_on = 1'b0;
        run_random(400);
    endtask

    // receiver readiness in random bursts
    always @(posedge i_clk) begin
        if (rdy_left != 0) begin
            rdy_left <= rdy_left - 1;
        end else if (idle_on && $urandom_range(0, 2) == 0) begin
            rdy_burst <= 1'b0;
            rdy_left  <= $urandom_range(1, 15);
        end else begin
            rdy_burst <= 1'b1;
            rdy_left  <= $urandom_range(1, 20);
        end
    end

    assign res_if.ready = rdy_burst && !res_hold;

    // long receiver hold-off so the block backs up into its input
    always begin
        @(posedge i_clk);
        if (stall_req != stall_done) begin
            res_hold <= 1'b1;
            repeat (LONG_STALL) @(posedge i_clk);
            res_hold <= 1'b0;
            stall_done++;
        end
    end

    always @(posedge i_clk) begin
        t_res_item want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            n_results++;
            if (vel_expected.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result, channel %0d velocity %0d", $time,
                         res_if.data.out_channel, res_if.data.velocity_mm_s);
            end else begin
                want = vel_expected.pop_front();
                if (res_if.data.out_channel !== want.out_channel) begin
                    n_errors++;
                    $display("%0t: out_channel mismatch, expected %0d, actual %0d", $time,
                             want.out_channel, res_if.data.out_channel);
                end
                if (res_if.data.velocity_mm_s !== want.velocity_mm_s) begin
                    n_errors++;
                    $display("%0t: velocity_mm_s mismatch, expected %0d, actual %0d", $time,
                             want.velocity_mm_s, res_if.data.velocity_mm_s);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("%0t: timeout with %0d results outstanding", $time, vel_expected.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        reset_predictor();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_unknown_register();
        test_random_default();
        test_saturation();
        test_random_wide();
        test_random_closed();
        test_random_stall();
        test_random_streaming();

        drain_block(TAIL_CYCLES);
        $display("covered %0d items: %0d samples, %0d polls, %0d results checked",
                 n_items, n_samples, n_polls, n_results);
        $display("%0d in-window velocities, %0d stale polls, %0d errors",
                 n_valid, n_stale, n_errors);
        if (n_errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
